// ----- sv/ptb_pkg.sv -----
package ptb_pkg;

   // Bank size and the widths that follow from it.
   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

   // Fixed field widths.
   localparam int TIME_W = 40;
   localparam int TICK_W = 20;
   localparam int ID_W   = 6;

   localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000);

   // Command codes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_SET  = 2'd0;
   localparam logic [1:0] KIND_FIRE = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Set reply status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      logic              command;
      logic [TIME_W-1:0] interval_us;
      logic              periodic;
   } ptb_req_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [1:0]      status;
      logic [ID_W-1:0] timer_id;
      logic            last;
   } ptb_rsp_type;

   // Write request into the slot store.
   typedef struct packed {
      logic              rem_en;
      logic              rel_en;
      logic [SLOT_W-1:0] addr;
      logic [TIME_W-1:0] rem_data;
      logic [TIME_W-1:0] rel_data;
   } ptb_wr_type;

endpackage

// ----- sv/ptb_slot_store.sv -----
module ptb_slot_store
   import ptb_pkg::*;
(
   input  logic              clock,
   input  ptb_wr_type        wr,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_rem,
   output logic [TIME_W-1:0] rd_rel
);

   logic [TIME_W-1:0] rem_mem [TIMER_SLOTS];
   logic [TIME_W-1:0] rel_mem [TIMER_SLOTS];
   logic [TIME_W-1:0] rd_rem_ff;
   logic [TIME_W-1:0] rd_rel_ff;

   // One write port per array, sharing the address.
   always_ff @(posedge clock) begin
      if (wr.rem_en) begin
         rem_mem[wr.addr] <= wr.rem_data;
      end
      if (wr.rel_en) begin
         rel_mem[wr.addr] <= wr.rel_data;
      end
   end

   // Registered read of both arrays at one address.
   always_ff @(posedge clock) begin
      rd_rem_ff <= rem_mem[rd_addr];
      rd_rel_ff <= rel_mem[rd_addr];
   end

   assign rd_rem = rd_rem_ff;
   assign rd_rel = rd_rel_ff;

endmodule

// ----- sv/ptb_alu.sv -----
module ptb_alu
   import ptb_pkg::*;
(
   input  logic [TIME_W-1:0] remaining,
   input  logic [TICK_W-1:0] tick,
   output logic              expired,
   output logic [TIME_W-1:0] diff
);

   logic [TIME_W:0] sub;

   // One wide subtract; a borrow or a zero result means the timer is due.
   assign sub     = {1'b0, remaining} - {{(TIME_W - TICK_W + 1){1'b0}}, tick};
   assign diff    = sub[TIME_W-1:0];
   assign expired = sub[TIME_W] || (sub[TIME_W-1:0] == '0);

endmodule

// ----- sv/periodic_one_shot_timer_bank_core.sv -----
// Channel   Ports                     Direction  Transfer
// -------   -----------------------   ---------  -----------------------------
// request   start, busy, req_data     in         start high while busy low
// response  rsp_strobe, rsp_data      out        one cycle per word, no stall
// csr       csr_we, csr_wdata         in         tick length, written on csr_we
//
// A set command leaves busy low; its reply word appears on the next cycle.
// A tick command keeps busy high until it issues the done word: the slot store
// has one read port, so the sequencer walks one slot per cycle through the
// shared subtractor, each slot resolving behind its registered read.
// Reset clears the masks, the slot count and the sequencer; tick length
// returns to 1000. The receiver cannot stall, so results never wait.
module periodic_one_shot_timer_bank_core
   import ptb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptb_req_type       req_data,
   output logic              rsp_strobe,
   output ptb_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [TICK_W-1:0] csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TICK = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [TICK_W-1:0]      tick_ff;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [SLOT_W-1:0]      ev_idx_ff, ev_idx_in;
   logic [TIMER_SLOTS-1:0] armed_ff, armed_in;
   logic [TIMER_SLOTS-1:0] periodic_ff, periodic_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ptb_rsp_type            rsp_ff, rsp_in;

   ptb_wr_type             wr;
   logic [TIME_W-1:0]      rd_rem;
   logic [TIME_W-1:0]      rd_rel;
   logic                   expired;
   logic [TIME_W-1:0]      diff;
   logic                   accept;
   logic                   ev_armed;
   logic                   ev_fire;

   ptb_slot_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (idx_ff[SLOT_W-1:0]),
      .rd_rem  (rd_rem),
      .rd_rel  (rd_rel)
   );

   ptb_alu u_alu (
      .remaining (rd_rem),
      .tick      (tick_ff),
      .expired   (expired),
      .diff      (diff)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign ev_armed = armed_ff[ev_idx_ff];
   assign ev_fire  = ev_valid_ff && ev_armed && expired;

   // Tick length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= TICK_RESET;
      end else if (csr_we) begin
         tick_ff <= csr_wdata;
      end
   end

   // Sequencer, masks, store writes and result word.
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      ev_valid_in  = 1'b0;
      ev_idx_in    = idx_ff[SLOT_W-1:0];
      armed_in     = armed_ff;
      periodic_in  = periodic_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr           = '0;
      wr.addr      = used_ff[SLOT_W-1:0];
      wr.rem_data  = req_data.interval_us;
      wr.rel_data  = req_data.interval_us;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_SET) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.kind     = KIND_SET;
                  rsp_in.timer_id = '0;
                  rsp_in.last     = 1'b1;
                  if (used_ff >= CNT_W'(TIMER_SLOTS)) begin
                     rsp_in.status = ST_FULL;
                  end else if (req_data.interval_us == '0) begin
                     rsp_in.status = ST_ZERO;
                  end else begin
                     rsp_in.status   = ST_OK;
                     rsp_in.timer_id = ID_W'(used_ff) + ID_W'(1);
                     wr.rem_en       = 1'b1;
                     wr.rel_en       = 1'b1;
                     armed_in[used_ff[SLOT_W-1:0]]    = 1'b1;
                     periodic_in[used_ff[SLOT_W-1:0]] = req_data.periodic;
                     used_in = used_ff + CNT_W'(1);
                  end
               end else begin
                  state_in = S_TICK;
                  idx_in   = '0;
               end
            end
         end
         S_TICK: begin
            // Issue the read for the next slot while the previous one resolves.
            if (idx_ff < CNT_W'(TIMER_SLOTS)) begin
               ev_valid_in = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
            end
            if (ev_valid_ff && ev_armed) begin
               wr.rem_en = 1'b1;
               wr.addr   = ev_idx_ff;
               if (expired) begin
                  if (periodic_ff[ev_idx_ff]) begin
                     wr.rem_data = rd_rel;
                  end else begin
                     wr.rem_data         = '0;
                     armed_in[ev_idx_ff] = 1'b0;
                  end
               end else begin
                  wr.rem_data = diff;
               end
            end
            if (ev_fire) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_FIRE;
               rsp_in.status   = ST_OK;
               rsp_in.timer_id = ID_W'(ev_idx_ff) + ID_W'(1);
               rsp_in.last     = 1'b0;
            end
            if (ev_valid_ff && (ev_idx_ff == SLOT_W'(TIMER_SLOTS - 1))) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in    = 1'b1;
            rsp_in.kind     = KIND_DONE;
            rsp_in.status   = ST_OK;
            rsp_in.timer_id = '0;
            rsp_in.last     = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         idx_ff       <= '0;
         ev_valid_ff  <= 1'b0;
         armed_ff     <= '0;
         periodic_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         ev_valid_ff  <= ev_valid_in;
         armed_ff     <= armed_in;
         periodic_ff  <= periodic_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ev_idx_ff <= ev_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
